// ----- design/tdia_pkg.sv -----
package tdia_pkg;

  // Coordinate and result formats
  localparam int COORD_W  = 16;
  localparam int OUT_W    = COORD_W + 1;
  localparam int SQ_W     = 2 * COORD_W;
  localparam int LEN_W    = 2 * COORD_W + 2;
  localparam int REM_W    = COORD_W + 2;
  localparam int SQ_STEPS = LEN_W / 2;

  // Geometry: four vertices, six vertex pairs
  localparam int NVERT = 4;
  localparam int NLANE = 6;
  localparam int PAIR_P [NLANE] = '{0, 0, 0, 1, 1, 2};
  localparam int PAIR_Q [NLANE] = '{1, 2, 3, 2, 3, 3};

  // Pipeline depth: three lane stages, two merge stages, one per root bit
  localparam int LANE_STAGES  = 3;
  localparam int MERGE_STAGES = 2;
  localparam int NSTAGE       = LANE_STAGES + MERGE_STAGES + SQ_STEPS;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [LEN_W-1:0]   len_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vtx_t;

  // Working state of the digit-by-digit square root
  typedef struct packed {
    logic [OUT_W-1:0] root;
    logic [REM_W-1:0] rem;
    len_t             rad;
  } sqst_t;

  // Magnitude of the difference of two signed coordinates
  function automatic logic [COORD_W-1:0] abs_diff(input coord_t a, input coord_t b);
    logic [COORD_W:0] d;
    logic [COORD_W:0] m;
    d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    m = d[COORD_W] ? (~d + 1'b1) : d;
    return m[COORD_W-1:0];
  endfunction

endpackage

// ----- design/tdia_lane.sv -----
module tdia_lane import tdia_pkg::*; (
  input  logic clk,
  input  logic adv,
  input  vtx_t va,
  input  vtx_t vb,
  output len_t len
);

  logic [COORD_W-1:0] mag [3];
  logic [SQ_W-1:0]    sq  [3];
  len_t               len_r;

  // Stage 1: per-axis distance
  always_ff @(posedge clk) begin
    if (adv) begin
      mag[0] <= abs_diff(va.x, vb.x);
      mag[1] <= abs_diff(va.y, vb.y);
      mag[2] <= abs_diff(va.z, vb.z);
    end
  end

  // Stage 2: squares
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        sq[i] <= SQ_W'(mag[i]) * SQ_W'(mag[i]);
      end
    end
  end

  // Stage 3: squared edge length
  always_ff @(posedge clk) begin
    if (adv) begin
      len_r <= LEN_W'(sq[0]) + LEN_W'(sq[1]) + LEN_W'(sq[2]);
    end
  end

  assign len = len_r;

endmodule

// ----- design/tdia_merge.sv -----
module tdia_merge import tdia_pkg::*; (
  input  logic clk,
  input  logic adv,
  input  len_t len_in [NLANE],
  output len_t best
);

  len_t pmax [NLANE/2];
  len_t best_r;
  len_t m01;

  // Stage 1: pairwise maximum
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NLANE/2; i++) begin
        pmax[i] <= (len_in[2*i] > len_in[2*i+1]) ? len_in[2*i] : len_in[2*i+1];
      end
    end
  end

  // Stage 2: maximum of the three survivors
  always_comb begin
    m01 = (pmax[0] > pmax[1]) ? pmax[0] : pmax[1];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      best_r <= (m01 > pmax[2]) ? m01 : pmax[2];
    end
  end

  assign best = best_r;

endmodule

// ----- design/tdia_sqrt_step.sv -----
module tdia_sqrt_step import tdia_pkg::*; (
  input  logic  clk,
  input  logic  adv,
  input  sqst_t st_in,
  output sqst_t st_out
);

  logic [REM_W+1:0] rem_s;
  logic [REM_W+1:0] trial;
  logic [REM_W+1:0] diff;
  logic             ge;
  sqst_t            st_next;
  sqst_t            st_r;

  // One root bit: bring down two radicand bits, try root*4+1
  always_comb begin
    rem_s        = {st_in.rem, st_in.rad[LEN_W-1 -: 2]};
    trial        = {1'b0, st_in.root, 2'b01};
    diff         = rem_s - trial;
    ge           = (rem_s >= trial);
    st_next.root = {st_in.root[OUT_W-2:0], ge};
    st_next.rem  = ge ? diff[REM_W-1:0] : rem_s[REM_W-1:0];
    st_next.rad  = {st_in.rad[LEN_W-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r <= st_next;
    end
  end

  assign st_out = st_r;

endmodule

// ----- design/tetrahedron_diameter.sv -----
// Longest edge of a tetrahedron. Each item brings four vertices as signed
// 16-bit coordinates; the block returns floor(sqrt(max squared edge length))
// as a 17-bit unsigned value in the coordinate scale. Six pair lanes (three
// stages: distance, square, sum), a two-stage max tree and a 17-stage
// square root (one root bit per stage) give a pipeline of 22 stages plus an
// output register, and one item is accepted every cycle while in_stall is
// low. Behind the output register sits a one-entry skid buffer; in_stall
// goes high only once that buffer is full, and the whole pipeline then holds
// until the output drains.
module tetrahedron_diameter import tdia_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [COORD_W-1:0] v0_x,
  input  logic [COORD_W-1:0] v0_y,
  input  logic [COORD_W-1:0] v0_z,
  input  logic [COORD_W-1:0] v1_x,
  input  logic [COORD_W-1:0] v1_y,
  input  logic [COORD_W-1:0] v1_z,
  input  logic [COORD_W-1:0] v2_x,
  input  logic [COORD_W-1:0] v2_y,
  input  logic [COORD_W-1:0] v2_z,
  input  logic [COORD_W-1:0] v3_x,
  input  logic [COORD_W-1:0] v3_y,
  input  logic [COORD_W-1:0] v3_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [OUT_W-1:0]   diameter
);

  vtx_t             vtx    [NVERT];
  len_t             lane_len [NLANE];
  len_t             best;
  sqst_t            sq_st  [SQ_STEPS+1];
  logic [NSTAGE-1:0] vld;
  logic             adv;
  logic             skid_vld;
  logic [OUT_W-1:0] skid_data;
  logic             o_vld;
  logic [OUT_W-1:0] o_data;
  logic             o_load;

  assign vtx[0] = '{x: v0_x, y: v0_y, z: v0_z};
  assign vtx[1] = '{x: v1_x, y: v1_y, z: v1_z};
  assign vtx[2] = '{x: v2_x, y: v2_y, z: v2_z};
  assign vtx[3] = '{x: v3_x, y: v3_y, z: v3_z};

  // Pipeline moves whenever the skid buffer is free
  assign adv      = !skid_vld;
  assign in_stall = skid_vld;

  // Edge lanes
  for (genvar g = 0; g < NLANE; g++) begin : g_lane
    tdia_lane u_lane (
      .clk (clk),
      .adv (adv),
      .va  (vtx[PAIR_P[g]]),
      .vb  (vtx[PAIR_Q[g]]),
      .len (lane_len[g])
    );
  end

  tdia_merge u_merge (
    .clk    (clk),
    .adv    (adv),
    .len_in (lane_len),
    .best   (best)
  );

  // Square root, one bit per stage
  assign sq_st[0] = '{root: '0, rem: '0, rad: best};

  for (genvar s = 0; s < SQ_STEPS; s++) begin : g_sqrt
    tdia_sqrt_step u_step (
      .clk    (clk),
      .adv    (adv),
      .st_in  (sq_st[s]),
      .st_out (sq_st[s+1])
    );
  end

  // Item valid tracking through the pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NSTAGE-2:0], in_valid};
    end
  end

  // Output register and skid buffer
  assign o_load = !o_vld || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_vld    <= 1'b0;
      skid_vld <= 1'b0;
    end else if (skid_vld) begin
      if (o_load) begin
        o_vld    <= 1'b1;
        skid_vld <= 1'b0;
      end
    end else if (o_load) begin
      o_vld <= vld[NSTAGE-1];
    end else if (vld[NSTAGE-1]) begin
      skid_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld) begin
      if (o_load) begin
        o_data <= skid_data;
      end
    end else if (o_load) begin
      o_data <= sq_st[SQ_STEPS].root;
    end else begin
      skid_data <= sq_st[SQ_STEPS].root;
    end
  end

  assign out_valid = o_vld;
  assign diameter  = o_data;

endmodule

// ----- design/tdia_chk.sv -----
module tdia_chk import tdia_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic [COORD_W-1:0] v0_x,
  input logic [COORD_W-1:0] v0_y,
  input logic [COORD_W-1:0] v0_z,
  input logic [COORD_W-1:0] v1_x,
  input logic [COORD_W-1:0] v1_y,
  input logic [COORD_W-1:0] v1_z,
  input logic [COORD_W-1:0] v2_x,
  input logic [COORD_W-1:0] v2_y,
  input logic [COORD_W-1:0] v2_z,
  input logic [COORD_W-1:0] v3_x,
  input logic [COORD_W-1:0] v3_y,
  input logic [COORD_W-1:0] v3_z,
  input logic               out_valid,
  input logic               out_stall,
  input logic [OUT_W-1:0]   diameter
);

  // Stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  // Stalled result does not change
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(diameter))
    else $error("diameter changed while stalled");

  // Input backpressure only follows a stalled output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("in_stall rose without output stall");

  // Reset empties the block
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && !in_stall)
    else $error("block not empty after reset");

endmodule

bind tetrahedron_diameter tdia_chk u_tdia_chk (.*);

// ----- dv/tb.sv -----
module tb;
  import tdia_pkg::*;

  // One tetrahedron: v0 x,y,z then v1, v2, v3
  typedef logic [0:11][COORD_W-1:0] tet_t;

  typedef struct packed {
    tet_t              tet;
    logic signed [31:0] want;
  } dir_row_t;

  // Shapes of random tetrahedra
  typedef enum int {MIX_FULL, MIX_SMALL, MIX_EXTREME, MIX_FLAT, MIX_AXIS} mix_e;

  localparam int     BY_MODEL    = -1;
  localparam int     N_DIR       = 17;
  localparam int     N_RANDOM    = 1583;
  localparam int     QUIET_FROM  = 1400;
  localparam int     HOLD_AT     = 300;
  localparam int     HOLD_CYCLES = 200;
  localparam coord_t C0          = '0;
  localparam coord_t CMIN        = 16'h8000;
  localparam coord_t CMAX        = 16'h7fff;

  logic   clk       = 1'b0;
  logic   rst       = 1'b1;
  logic   in_valid  = 1'b0;
  logic   out_stall = 1'b0;
  coord_t v0_x = '0, v0_y = '0, v0_z = '0;
  coord_t v1_x = '0, v1_y = '0, v1_z = '0;
  coord_t v2_x = '0, v2_y = '0, v2_z = '0;
  coord_t v3_x = '0, v3_y = '0, v3_z = '0;
  logic             in_stall;
  logic             out_valid;
  logic [OUT_W-1:0] diameter;

  logic [OUT_W-1:0] diam_due [$];
  logic [OUT_W-1:0] head_diam;
  dir_row_t         dir_tbl [N_DIR];
  bit               idle_on   = 1'b1;
  bit               hold_req  = 1'b0;
  bit               hold_done = 1'b0;
  int               n_errors  = 0;
  int               n_sent    = 0;
  int               n_checked = 0;
  int               stall_run = 0;
  int               stall_max = 0;

  tetrahedron_diameter u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .v0_x      (v0_x),
    .v0_y      (v0_y),
    .v0_z      (v0_z),
    .v1_x      (v1_x),
    .v1_y      (v1_y),
    .v1_z      (v1_z),
    .v2_x      (v2_x),
    .v2_y      (v2_y),
    .v2_z      (v2_z),
    .v3_x      (v3_x),
    .v3_y      (v3_y),
    .v3_z      (v3_z),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .diameter  (diameter)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Exact longest edge: max of six squared lengths, then floor square root
  function automatic logic [OUT_W-1:0] longest_edge(input tet_t t);
    logic signed [COORD_W:0] d;
    longint unsigned         len;
    longint unsigned         best;
    longint unsigned         tsq;
    logic [OUT_W-1:0]        root;
    logic [OUT_W-1:0]        trial;
    best = 0;
    for (int p = 0; p < NVERT - 1; p++) begin
      for (int q = p + 1; q < NVERT; q++) begin
        len = 0;
        for (int k = 0; k < 3; k++) begin
          d = $signed({t[3*p+k][COORD_W-1], t[3*p+k]}) -
              $signed({t[3*q+k][COORD_W-1], t[3*q+k]});
          len += longint'(d) * longint'(d);
        end
        if (len > best) best = len;
      end
    end
    // Build the root one bit at a time, MSB first
    root = '0;
    for (int b = OUT_W - 1; b >= 0; b--) begin
      trial = root | (OUT_W'(1) << b);
      tsq   = longint'(trial) * longint'(trial);
      if (tsq <= best) root = trial;
    end
    return root;
  endfunction

  function automatic tet_t rand_tet();
    tet_t   t;
    mix_e   mix;
    coord_t base [3];
    mix = mix_e'($urandom_range(0, 4));
    t   = '0;
    case (mix)
      MIX_FULL: begin
        for (int k = 0; k < 12; k++) t[k] = coord_t'($urandom());
      end
      MIX_SMALL: begin
        for (int k = 0; k < 12; k++) t[k] = coord_t'($urandom_range(0, 15)) - 16'd8;
      end
      MIX_EXTREME: begin
        for (int k = 0; k < 12; k++) begin
          case ($urandom_range(0, 4))
            0:       t[k] = CMIN;
            1:       t[k] = CMAX;
            2:       t[k] = C0;
            3:       t[k] = 16'hffff;
            default: t[k] = 16'h0001;
          endcase
        end
      end
      MIX_FLAT: begin
        // nearly coincident vertices around a random point
        for (int k = 0; k < 3; k++) base[k] = coord_t'($urandom());
        for (int k = 0; k < 12; k++)
          t[k] = base[k % 3] + coord_t'($urandom_range(0, 4)) - 16'd2;
      end
      default: begin
        // one nonzero coordinate: exact square roots
        t[$urandom_range(0, 11)] = coord_t'($urandom());
      end
    endcase
    return t;
  endfunction

  // Offer one item, optionally after a gap; log its diameter once accepted
  task automatic offer(input tet_t t, input int want);
    logic [OUT_W-1:0] due;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    due = (want == BY_MODEL) ? longest_edge(t) : OUT_W'(want);
    v0_x <= t[0];  v0_y <= t[1];  v0_z <= t[2];
    v1_x <= t[3];  v1_y <= t[4];  v1_z <= t[5];
    v2_x <= t[6];  v2_y <= t[7];  v2_z <= t[8];
    v3_x <= t[9];  v3_y <= t[10]; v3_z <= t[11];
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    diam_due.push_back(due);
    n_sent++;
  endtask

  // Result side: random stalls, one long hold-off, quiet at the end
  initial begin
    while (rst) @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        if (idle_on) repeat ($urandom_range(1, 16)) @(posedge clk);
        else @(posedge clk);
      end
    end
  end

  // Check each accepted diameter against the oldest one due
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_stall) begin
        stall_run++;
        if (stall_run > stall_max) stall_max = stall_run;
      end else begin
        stall_run = 0;
      end
      if (out_valid && !out_stall) begin
        if (diam_due.size() == 0) begin
          $error("diameter: unexpected item, actual %0d", diameter);
          n_errors++;
        end else begin
          head_diam = diam_due.pop_front();
          n_checked++;
          if (diameter !== head_diam) begin
            $error("diameter: expected %0d, actual %0d", head_diam, diameter);
            n_errors++;
          end
        end
      end
    end
  end

  initial begin
    // v0 x,y,z | v1 x,y,z | v2 x,y,z | v3 x,y,z
    dir_tbl = '{
      '{tet: '{C0, C0, C0, C0, C0, C0, C0, C0, C0, C0, C0, C0}, want: 0},
      '{tet: '{C0, C0, C0, CMAX, C0, C0, C0, C0, C0, C0, C0, C0}, want: 32767},
      '{tet: '{C0, C0, C0, CMIN, C0, C0, C0, C0, C0, C0, C0, C0}, want: 32768},
      '{tet: '{CMIN, C0, C0, CMAX, C0, C0, C0, C0, C0, C0, C0, C0}, want: 65535},
      '{tet: '{CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN},
        want: 113509},
      '{tet: '{CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX},
        want: 113509},
      '{tet: '{C0, C0, C0, C0, C0, C0, C0, C0, CMAX, C0, C0, CMIN}, want: 65535},
      '{tet: '{C0, C0, C0, C0, CMIN, C0, C0, CMAX, C0, C0, C0, C0}, want: 65535},
      '{tet: '{CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, C0, C0, C0, C0, C0, C0}, want: 113509},
      // degenerate: all vertices at one point
      '{tet: '{16'sd1234, -16'sd5, 16'sd77, 16'sd1234, -16'sd5, 16'sd77,
               16'sd1234, -16'sd5, 16'sd77, 16'sd1234, -16'sd5, 16'sd77}, want: 0},
      '{tet: '{CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN},
        want: 0},
      '{tet: '{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX},
        want: 0},
      '{tet: '{C0, C0, C0, 16'sd1, 16'sd1, 16'sd1, C0, C0, C0, C0, C0, C0}, want: 1},
      '{tet: '{C0, C0, C0, 16'sd3, 16'sd4, C0, C0, C0, 16'sd12, C0, C0, C0}, want: 13},
      '{tet: '{C0, C0, C0, -16'sd2, -16'sd2, -16'sd2, C0, C0, C0, C0, C0, C0}, want: 3},
      '{tet: '{16'h5555, 16'h5555, 16'h5555, 16'haaaa, 16'haaaa, 16'haaaa,
               16'h00ff, 16'hff00, 16'h0f0f, 16'hf0f0, 16'h3333, 16'hcccc},
        want: BY_MODEL},
      '{tet: '{CMAX, CMIN, C0, 16'hffff, 16'h0001, CMAX,
               CMIN, CMIN, CMIN, 16'h0001, 16'hffff, C0}, want: BY_MODEL}
    };
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tbl[i]) offer(dir_tbl[i].tet, dir_tbl[i].want);

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == HOLD_AT)    hold_req = 1'b1;
      if (i == QUIET_FROM) idle_on  = 1'b0;
      offer(rand_tet(), BY_MODEL);
    end
    in_valid <= 1'b0;

    // Drain, then give stray items time to show up
    for (int k = 0; k < 5000 && diam_due.size() != 0; k++) @(posedge clk);
    if (diam_due.size() != 0) begin
      $error("diameter: %0d items never arrived", diam_due.size());
      n_errors++;
    end
    repeat (40) @(posedge clk);

    $display("Sent %0d tetrahedra (%0d from the table, %0d random), %0d diameters checked.",
             n_sent, N_DIR, N_RANDOM, n_checked);
    $display("Longest run of input backpressure: %0d cycles.", stall_max);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- tetrahedron_diameter.f -----
design/tdia_pkg.sv
design/tdia_lane.sv
design/tdia_merge.sv
design/tdia_sqrt_step.sv
design/tetrahedron_diameter.sv
design/tdia_chk.sv
dv/tb.sv
